FILE: design/qte_pkg.sv
// Shared widths, the queue entry type and the CORDIC arctangent constants.
package qte_pkg;

  localparam int CORDIC_STAGES_DEF  = 16;
  localparam int COMPONENT_BITS_DEF = 16;

  localparam int ATAN_LEN   = 24;
  localparam int COMP_W     = 16;  // aligned component, Q2.14
  localparam int PROD_W     = 32;  // component product, Q28
  localparam int SUM_W      = 34;  // atan2 operands before the CORDIC
  localparam int S_W        = 30;  // clamped pitch sine, +-2^28
  localparam int SQ_W       = 57;  // square of the pitch sine
  localparam int RES_W      = 58;  // square root working width
  localparam int ROOT_STEPS = 29;  // one result bit per step
  localparam int XY_W       = 38;  // CORDIC vector width with gain headroom
  localparam int ANG_W      = 34;  // angle, 2^31 = pi
  localparam int BA_W       = 18;  // rounded binary angle before wrap
  localparam int OUT_W      = 16;

  localparam logic signed [SUM_W-1:0] ONE_Q28  = 34'sd268435456;
  localparam logic [RES_W-1:0]        ONE_SQ   = RES_W'(1) << 56;
  localparam logic signed [ANG_W-1:0] HALF_PI  = 34'sd1073741824;
  localparam logic signed [ANG_W-1:0] ROUND_HALF = 34'sd32768;
  localparam logic signed [BA_W-1:0]  PITCH_MAX = 18'sd16384;

  typedef struct packed {
    logic signed [SUM_W-1:0] roll_y;
    logic signed [SUM_W-1:0] roll_x;
    logic signed [SUM_W-1:0] yaw_y;
    logic signed [SUM_W-1:0] yaw_x;
    logic signed [S_W-1:0]   s;
    logic [SQ_W-1:0]         s_sq;
    logic                    sat;
  } qte_op_t;

  function automatic logic signed [ANG_W-1:0] atan_const(input int idx);
    logic signed [ANG_W-1:0] v;
    unique case (idx)
      0:  v = 34'sd536870912;
      1:  v = 34'sd316933406;
      2:  v = 34'sd167458907;
      3:  v = 34'sd85004756;
      4:  v = 34'sd42667331;
      5:  v = 34'sd21354465;
      6:  v = 34'sd10679838;
      7:  v = 34'sd5340245;
      8:  v = 34'sd2670163;
      9:  v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/qte_front.sv
// Front end: align components, form products and atan2 operands, clamp pitch sine.
module qte_front #(
  parameter int COMPONENT_BITS = qte_pkg::COMPONENT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  logic signed [qte_pkg::COMP_W-1:0]  q_w,
  input  logic signed [qte_pkg::COMP_W-1:0]  q_x,
  input  logic signed [qte_pkg::COMP_W-1:0]  q_y,
  input  logic signed [qte_pkg::COMP_W-1:0]  q_z,
  output logic                               push,
  output qte_pkg::qte_op_t                   op
);
  import qte_pkg::*;

  localparam int SHR = (COMPONENT_BITS > COMP_W) ? COMPONENT_BITS - COMP_W : 0;
  localparam int SHL = (COMPONENT_BITS < COMP_W) ? COMP_W - COMPONENT_BITS : 0;

  logic signed [COMP_W-1:0] raw [4];
  logic signed [COMP_W-1:0] algn [4];
  logic signed [COMP_W-1:0] comp_r [4];
  logic v0_r, v1_r, v2_r, v3_r;

  logic signed [PROD_W-1:0] ww_r, xx_r, yy_r, zz_r, wx_r, yz_r, wz_r, xy_r, wy_r, zx_r;
  logic signed [SUM_W-1:0]  roll_y_r, roll_x_r, yaw_y_r, yaw_x_r;
  logic signed [SUM_W-1:0]  s_full;
  logic signed [S_W-1:0]    s_r, s_nxt;
  logic                     sat_r, sat_nxt;
  logic signed [2*S_W-1:0]  sq_full;
  qte_op_t                  op_r;

  assign raw[0] = q_w;
  assign raw[1] = q_x;
  assign raw[2] = q_y;
  assign raw[3] = q_z;

  for (genvar k = 0; k < 4; k++) begin : g_align
    if (COMPONENT_BITS > COMP_W) begin : g_shr
      // Upper component bits are absent, so the value is never negative.
      assign algn[k] = $signed(COMP_W'($unsigned(raw[k]) >> SHR));
    end else begin : g_shl
      assign algn[k] = raw[k] <<< SHL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= accept;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      comp_r[k] <= algn[k];
    end
  end

  // One multiplier per product.
  always_ff @(posedge clk) begin
    ww_r <= comp_r[0] * comp_r[0];
    xx_r <= comp_r[1] * comp_r[1];
    yy_r <= comp_r[2] * comp_r[2];
    zz_r <= comp_r[3] * comp_r[3];
    wx_r <= comp_r[0] * comp_r[1];
    yz_r <= comp_r[2] * comp_r[3];
    wz_r <= comp_r[0] * comp_r[3];
    xy_r <= comp_r[1] * comp_r[2];
    wy_r <= comp_r[0] * comp_r[2];
    zx_r <= comp_r[3] * comp_r[1];
  end

  always_comb begin
    s_full = (SUM_W'(wy_r) - SUM_W'(zx_r)) <<< 1;
    priority if (s_full > ONE_Q28) begin
      s_nxt   = S_W'(ONE_Q28);
      sat_nxt = 1'b1;
    end else if (s_full < -ONE_Q28) begin
      s_nxt   = S_W'(-ONE_Q28);
      sat_nxt = 1'b1;
    end else begin
      s_nxt   = S_W'(s_full);
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    roll_y_r <= (SUM_W'(wx_r) + SUM_W'(yz_r)) <<< 1;
    roll_x_r <= SUM_W'(ww_r) - SUM_W'(xx_r) - SUM_W'(yy_r) + SUM_W'(zz_r);
    yaw_y_r  <= (SUM_W'(wz_r) + SUM_W'(xy_r)) <<< 1;
    yaw_x_r  <= SUM_W'(ww_r) + SUM_W'(xx_r) - SUM_W'(yy_r) - SUM_W'(zz_r);
    s_r      <= s_nxt;
    sat_r    <= sat_nxt;
  end

  assign sq_full = s_r * s_r;

  always_ff @(posedge clk) begin
    op_r.roll_y <= roll_y_r;
    op_r.roll_x <= roll_x_r;
    op_r.yaw_y  <= yaw_y_r;
    op_r.yaw_x  <= yaw_x_r;
    op_r.s      <= s_r;
    op_r.s_sq   <= SQ_W'($unsigned(sq_full));
    op_r.sat    <= sat_r;
  end

  assign push = v3_r;
  assign op   = op_r;

endmodule

FILE: design/qte_queue.sv
// Two-entry queue between the front end and the back end.
module qte_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  qte_pkg::qte_op_t wr_data,
  output logic             full,
  output logic             rd_valid,
  output qte_pkg::qte_op_t rd_data
);
  import qte_pkg::*;

  qte_op_t    mem_r [2];
  logic [1:0] cnt_r;
  logic       wp_r, rp_r;
  logic       wr, pop;

  assign full     = (cnt_r == 2'd2);
  assign wr       = push && !full;
  assign pop      = (cnt_r != 2'd0);  // back end drains every cycle
  assign rd_valid = pop;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (wr) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(wr) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd1)
    else $error("queue holds more than one item");
  a_empty_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> wp_r == rp_r)
    else $error("queue pointers differ while empty");
  a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> cnt_r != 2'd0)
    else $error("pushed item not held");

endmodule

FILE: design/qte_cordic.sv
// Pipelined vectoring CORDIC: angle of (x, y), 2^31 = pi.
module qte_cordic #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic signed [qte_pkg::XY_W-1:0]   y_in,
  input  logic signed [qte_pkg::XY_W-1:0]   x_in,
  output logic signed [qte_pkg::ANG_W-1:0]  angle
);
  import qte_pkg::*;

  logic signed [XY_W-1:0]  x_r [CORDIC_STAGES+1];
  logic signed [XY_W-1:0]  y_r [CORDIC_STAGES+1];
  logic signed [ANG_W-1:0] a_r [CORDIC_STAGES+1];
  logic                    zero_r [CORDIC_STAGES+1];

  // Move the left half plane into the right one.
  always_ff @(posedge clk) begin
    zero_r[0] <= (x_in == '0) && (y_in == '0);
    if (x_in < 0) begin
      if (y_in >= 0) begin
        x_r[0] <= y_in;
        y_r[0] <= -x_in;
        a_r[0] <= HALF_PI;
      end else begin
        x_r[0] <= -y_in;
        y_r[0] <= x_in;
        a_r[0] <= -HALF_PI;
      end
    end else begin
      x_r[0] <= x_in;
      y_r[0] <= y_in;
      a_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [XY_W-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      zero_r[i+1] <= zero_r[i];
      if (y_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] + dx;
        y_r[i+1] <= y_r[i] - dy;
        a_r[i+1] <= a_r[i] + atan_const(i);
      end else begin
        x_r[i+1] <= x_r[i] - dx;
        y_r[i+1] <= y_r[i] + dy;
        a_r[i+1] <= a_r[i] - atan_const(i);
      end
    end
  end

  assign angle = zero_r[CORDIC_STAGES] ? '0 : a_r[CORDIC_STAGES];

endmodule

FILE: design/qte_back.sv
// Back end: pitch cosine by square root, three CORDICs, rounding to binary angles.
module qte_back #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  qte_pkg::qte_op_t                  op,
  output logic                              out_valid,
  output logic signed [qte_pkg::OUT_W-1:0]  roll_angle,
  output logic signed [qte_pkg::OUT_W-1:0]  pitch_angle,
  output logic signed [qte_pkg::OUT_W-1:0]  yaw_angle,
  output logic                              pitch_saturated
);
  import qte_pkg::*;

  localparam int V_LEN = ROOT_STEPS + CORDIC_STAGES + 3;

  logic [V_LEN-1:0]       v_r;
  logic [RES_W-1:0]       n0_r;
  qte_op_t                op0_r;
  logic [RES_W-1:0]       rn_r   [ROOT_STEPS];
  logic [RES_W-1:0]       rres_r [ROOT_STEPS];
  qte_op_t                rop_r  [ROOT_STEPS];
  logic [CORDIC_STAGES:0] sat_d_r;
  qte_op_t                last_op;
  logic signed [ANG_W-1:0] roll_a, pitch_a, yaw_a;
  logic signed [ANG_W-1:0] roll_rs, pitch_rs, yaw_rs;
  logic signed [BA_W-1:0]  roll_b, pitch_b, yaw_b, pitch_c;
  logic signed [OUT_W-1:0] roll_r, pitch_r, yaw_r;
  logic                    sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[V_LEN-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    n0_r  <= ONE_SQ - RES_W'(op.s_sq);
    op0_r <= op;
  end

  // Restoring square root, one result bit per stage.
  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
    localparam logic [RES_W-1:0] BIT = RES_W'(1) << (2 * (ROOT_STEPS - 1 - j));
    logic [RES_W-1:0] n_in, res_in, trial;
    qte_op_t          op_in;
    if (j == 0) begin : g_first
      assign n_in   = n0_r;
      assign res_in = '0;
      assign op_in  = op0_r;
    end else begin : g_next
      assign n_in   = rn_r[j-1];
      assign res_in = rres_r[j-1];
      assign op_in  = rop_r[j-1];
    end
    assign trial = res_in + BIT;
    always_ff @(posedge clk) begin
      if (n_in >= trial) begin
        rn_r[j]   <= n_in - trial;
        rres_r[j] <= (res_in >> 1) + BIT;
      end else begin
        rn_r[j]   <= n_in;
        rres_r[j] <= res_in >> 1;
      end
      rop_r[j] <= op_in;
    end
  end

  assign last_op = rop_r[ROOT_STEPS-1];

  always_ff @(posedge clk) begin
    sat_d_r <= {sat_d_r[CORDIC_STAGES-1:0], last_op.sat};
  end

  qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk   (clk),
    .y_in  (XY_W'(last_op.roll_y)),
    .x_in  (XY_W'(last_op.roll_x)),
    .angle (roll_a)
  );

  qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk   (clk),
    .y_in  (XY_W'(last_op.s)),
    .x_in  (XY_W'($signed({1'b0, rres_r[ROOT_STEPS-1][S_W-1:0]}))),
    .angle (pitch_a)
  );

  qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
    .clk   (clk),
    .y_in  (XY_W'(last_op.yaw_y)),
    .x_in  (XY_W'(last_op.yaw_x)),
    .angle (yaw_a)
  );

  // Round half up to 16-bit binary angles.
  assign roll_rs  = (roll_a + ROUND_HALF) >>> 16;
  assign pitch_rs = (pitch_a + ROUND_HALF) >>> 16;
  assign yaw_rs   = (yaw_a + ROUND_HALF) >>> 16;
  assign roll_b   = BA_W'(roll_rs);
  assign pitch_b  = BA_W'(pitch_rs);
  assign yaw_b    = BA_W'(yaw_rs);

  always_comb begin
    priority if (pitch_b > PITCH_MAX) begin
      pitch_c = PITCH_MAX;
    end else if (pitch_b < -PITCH_MAX) begin
      pitch_c = -PITCH_MAX;
    end else begin
      pitch_c = pitch_b;
    end
  end

  always_ff @(posedge clk) begin
    roll_r  <= OUT_W'(roll_b);
    pitch_r <= OUT_W'(pitch_c);
    yaw_r   <= OUT_W'(yaw_b);
    sat_r   <= sat_d_r[CORDIC_STAGES];
  end

  assign out_valid       = v_r[V_LEN-1];
  assign roll_angle      = roll_r;
  assign pitch_angle     = pitch_r;
  assign yaw_angle       = yaw_r;
  assign pitch_saturated = sat_r;

endmodule

FILE: design/quaternion_to_euler_angles_core.sv
// Top level of the quaternion to roll, pitch and yaw converter.
//
// Usage:
//   Present a quaternion on in_q_w..in_q_z (signed Q2.14 by default) and raise
//   start; the item is taken at a rising edge where start is high and busy low.
//   Items may be issued on every cycle. busy comes from the queue between the
//   front end and the back end; the back end drains that queue every cycle, so
//   busy stays low in operation.
//   Each result shows on out_roll_angle, out_pitch_angle, out_yaw_angle and
//   out_pitch_saturated for exactly one cycle with out_valid high, in the
//   order of the inputs. The receiver has no way to hold results off.
//   The path from accept to out_valid runs through 4 front-end stages, the
//   queue, the square-root operand register, 29 square-root steps for the
//   pitch cosine, CORDIC_STAGES + 1 CORDIC stages and the rounding register.
//   One item is taken per cycle, as the square root and CORDIC units are
//   fully pipelined.
//   Reset (rst_n low at a clock edge) empties the queue and drops every item in
//   flight; no result comes out for them.
module quaternion_to_euler_angles_core #(
  parameter int CORDIC_STAGES  = qte_pkg::CORDIC_STAGES_DEF,
  parameter int COMPONENT_BITS = qte_pkg::COMPONENT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [qte_pkg::COMP_W-1:0]  in_q_w,
  input  logic signed [qte_pkg::COMP_W-1:0]  in_q_x,
  input  logic signed [qte_pkg::COMP_W-1:0]  in_q_y,
  input  logic signed [qte_pkg::COMP_W-1:0]  in_q_z,
  output logic                               out_valid,
  output logic signed [qte_pkg::OUT_W-1:0]   out_roll_angle,
  output logic signed [qte_pkg::OUT_W-1:0]   out_pitch_angle,
  output logic signed [qte_pkg::OUT_W-1:0]   out_yaw_angle,
  output logic                               out_pitch_saturated
);
  import qte_pkg::*;

  logic    accept;
  logic    push;
  qte_op_t front_op;
  logic    q_full;
  logic    q_valid;
  qte_op_t q_op;

  // Take an item when the queue has room.
  assign accept = start && !busy;
  assign busy   = q_full;

  // Front end: align, multiply, form the atan2 operands, clamp the pitch sine.
  qte_front #(.COMPONENT_BITS(COMPONENT_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .q_w    (in_q_w),
    .q_x    (in_q_x),
    .q_y    (in_q_y),
    .q_z    (in_q_z),
    .push   (push),
    .op     (front_op)
  );

  // Decouple the two halves.
  qte_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_data  (front_op),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_data  (q_op)
  );

  // Back end: square root for the pitch cosine, then three CORDICs and rounding.
  qte_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (q_valid),
    .op              (q_op),
    .out_valid       (out_valid),
    .roll_angle      (out_roll_angle),
    .pitch_angle     (out_pitch_angle),
    .yaw_angle       (out_yaw_angle),
    .pitch_saturated (out_pitch_saturated)
  );

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_angle <= 16'sd16384) && (out_pitch_angle >= -16'sd16384))
    else $error("pitch outside half pi");
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("queue filled up");
  a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> q_valid)
    else $error("queued item not offered to back end");

endmodule
